[rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// shared constants, tables and round functions of the sha-256 byte hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int RoundCount = 64;

  typedef logic [31:0] word_t;

  localparam word_t RoundK [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // request from the controller to the compression core
  typedef struct packed {
    logic start;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

[rtl/sha256_core.sv]
// ----------------------------------------------------------------------------
// sha256_core
// 64-round compression, one round per cycle; the first 16 schedule words
// live in a 16-entry memory, read in the cycle before their round
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::core_req_t  req,
  output sha256_pkg::core_stat_t stat,
  // block buffer load port, written by the controller before start
  input  logic                   blk_we,
  input  logic [3:0]             blk_addr,
  input  sha256_pkg::word_t      blk_data,
  input  logic                   chain_init,
  input  logic [2:0]             chain_sel,
  output sha256_pkg::word_t      chain_word
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD} state_t;

  state_t state;
  logic [5:0] rnd;
  sha256_pkg::word_t sched_mem [16];
  sha256_pkg::word_t chain [8];
  sha256_pkg::word_t v [8];
  // last sixteen schedule words as shift taps for the recurrence
  sha256_pkg::word_t wt [16];
  sha256_pkg::word_t w_cur;
  sha256_pkg::word_t w_new;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t mj;
  sha256_pkg::word_t rd_data;
  logic [3:0] rd_addr;

  // read address: the word needed by the next round (first 16 only)
  always_comb begin
    rd_addr = rnd[3:0] + 4'd1;
    if (state == S_IDLE) begin
      rd_addr = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      sched_mem[blk_addr] <= blk_data;
    end
    rd_data <= sched_mem[rd_addr];
  end

  assign w_new = sha256_pkg::small_s1(wt[14]) + wt[9] + sha256_pkg::small_s0(wt[1]) + wt[0];
  assign w_cur = (rnd < 6'd16) ? rd_data : w_new;
  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign mj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + sha256_pkg::big_s1(v[4]) + ch + sha256_pkg::RoundK[rnd] + w_cur;
  assign t2    = sha256_pkg::big_s0(v[0]) + mj;

  assign chain_word = chain[chain_sel];
  assign stat.busy  = (state != S_IDLE);
  assign stat.done  = (state == S_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::InitHash[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (chain_init) begin
            for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::InitHash[i];
          end
          if (req.start) begin
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
            rnd   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          for (int i = 0; i < 15; i++) wt[i] <= wt[i + 1];
          wt[15] <= w_cur;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'(sha256_pkg::RoundCount - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sha256_byte_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// sha-256 over a byte stream, digest emitted as eight 32-bit words
// ----------------------------------------------------------------------------
// usage
// - input channel (valid/ready): one message byte per word when has_byte is
//   set; last closes the message, with or without a byte of its own
// - output channel (valid/ready): eight digest words, word_index 0 first,
//   last_word marks index 7
// - a byte that neither fills a block nor ends the message is taken back to back
// - the byte that completes a 64-byte block holds off input through the
//   compression (start, 64 rounds, feed-forward) and the zeroing of the
//   block memory for the next block
// - the block buffer is a 16-word memory in the core; a block is written
//   into it word by word as bytes pack, so a full block costs no copy
// - after a last word come the pad, two length writes, compression and clear,
//   with one more compression and clear when a second block is needed (under
//   nine bytes of room left, or the message ended on a block edge); then the
//   eight digest words, one per cycle while the receiver takes them
// - a stalled receiver holds the current digest word; no input is taken
//   until the last digest word leaves
// - reset returns the chain value to the initial hash, clears the byte count
//   and length, then a pass zeroes all sixteen block memory words before input
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [3:0] {
    S_TAKE, S_WCLR, S_CMP, S_PAD, S_PADCLR, S_LEN_HI, S_LEN_LO, S_FIN, S_OUT
  } state_t;

  state_t state;
  state_t ret_state;
  logic [5:0]  byte_pos;
  logic [63:0] bit_len;
  logic [31:0] acc;        // word being packed, not yet in memory
  logic        final_pend; // last seen, padding still to do
  logic [3:0]  clr_idx;
  logic [2:0]  out_idx;
  logic        pad_done;

  sha256_pkg::core_req_t  req;
  sha256_pkg::core_stat_t stat;
  logic               blk_we;
  logic [3:0]         blk_addr;
  sha256_pkg::word_t  blk_data;
  logic               chain_init;
  sha256_pkg::word_t  chain_word;

  logic [31:0] acc_in;
  logic [31:0] acc_pad;
  logic        take;

  assign take = in_valid && in_ready;
  assign in_ready = (state == S_TAKE);

  // packed byte or pad byte merged into current word
  always_comb begin
    acc_in = acc;
    acc_in[5'(24 - 8 * byte_pos[1:0]) +: 8] = data_byte;
    acc_pad = acc;
    acc_pad[5'(24 - 8 * byte_pos[1:0]) +: 8] = sha256_pkg::PadByte;
  end

  // memory write: whole words as they complete, padding, length and clearing words
  always_comb begin
    blk_we   = 1'b0;
    blk_addr = byte_pos[5:2];
    blk_data = acc_in;
    chain_init = (state == S_OUT) && out_ready && (out_idx == 3'd7);
    req.start = 1'b0;
    unique case (state)
      S_TAKE: begin
        blk_we = take && has_byte && (byte_pos[1:0] == 2'd3);
      end
      S_WCLR, S_PADCLR: begin
        blk_we   = 1'b1;
        blk_addr = clr_idx;
        blk_data = '0;
      end
      S_CMP: begin
        req.start = !stat.busy;
      end
      S_PAD: begin
        blk_we   = 1'b1;
        blk_data = acc_pad;
      end
      S_LEN_HI: begin
        blk_we   = 1'b1;
        blk_addr = 4'd14;
        blk_data = bit_len[63:32];
      end
      S_LEN_LO: begin
        blk_we   = 1'b1;
        blk_addr = 4'd15;
        blk_data = bit_len[31:0];
      end
      default: ;
    endcase
  end

  sha256_core u_core (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .stat       (stat),
    .blk_we     (blk_we),
    .blk_addr   (blk_addr),
    .blk_data   (blk_data),
    .chain_init (chain_init),
    .chain_sel  (out_idx),
    .chain_word (chain_word)
  );

  assign out_valid  = (state == S_OUT);
  assign hash_word  = chain_word;
  assign word_index = out_idx;
  assign last_word  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WCLR;
      ret_state  <= S_TAKE;
      byte_pos   <= '0;
      bit_len    <= '0;
      acc        <= '0;
      final_pend <= 1'b0;
      clr_idx    <= '0;
      out_idx    <= '0;
    end else begin
      unique case (state)
        // zero the block memory words ahead of a new block
        S_WCLR: begin
          clr_idx <= clr_idx + 4'd1;
          if (clr_idx == 4'd15) begin
            if (ret_state == S_PADCLR) begin
              // either a spill block (pad already written) or message ended on edge
              state     <= (bit_len[8:3] == 6'd0 && final_pend && !pad_done) ? S_PAD : S_LEN_HI;
              ret_state <= S_TAKE;
            end else begin
              state <= ret_state;
            end
          end
        end
        S_TAKE: begin
          if (take) begin
            if (has_byte) begin
              bit_len  <= bit_len + 64'd8;
              byte_pos <= byte_pos + 6'd1;
              acc      <= (byte_pos[1:0] == 2'd3) ? '0 : acc_in;
            end
            if (has_byte && byte_pos == 6'd63) begin
              final_pend <= last;
              state      <= S_CMP;
            end else if (last) begin
              if (has_byte) begin
                state <= S_PAD;
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        // pad byte goes in at byte_pos (acc already holds earlier bytes)
        S_PAD: begin
          acc <= '0;
          if (byte_pos >= 6'd56) begin
            // length spills to a second block
            state <= S_CMP;
            final_pend <= 1'b1;
            byte_pos <= '0;
          end else begin
            final_pend <= 1'b0;
            state <= S_LEN_HI;
          end
        end
        S_LEN_HI: state <= S_LEN_LO;
        S_LEN_LO: begin
          final_pend <= 1'b0;
          ret_state  <= S_FIN;
          state      <= S_CMP;
        end
        S_CMP: begin
          if (stat.done) begin
            clr_idx <= '0;
            state   <= S_WCLR;
            if (ret_state == S_FIN) begin
              ret_state <= S_OUT;
            end else if (final_pend) begin
              ret_state <= (byte_pos == 6'd0) ? S_PADCLR : S_TAKE;
            end else begin
              ret_state <= S_TAKE;
            end
          end
        end
        // a finished block whose message ended exactly at its edge, or the
        // spill block: after clearing, pad (if not done) and length
        S_PADCLR: begin
          state <= S_PAD;
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              byte_pos   <= '0;
              bit_len    <= '0;
              acc        <= '0;
              final_pend <= 1'b0;
              ret_state  <= S_TAKE;
              state      <= S_TAKE;
            end
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end

  // pad marker: set once the 0x80 byte has been written for this message
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_done <= 1'b0;
    end else if (state == S_PAD) begin
      pad_done <= 1'b1;
    end else if (state == S_OUT) begin
      pad_done <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_ready)
    else $error("input accepted during compression");
  a_out_only_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !stat.busy)
    else $error("digest shown while core busy");
  a_idx_adv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the sha-256 byte stream hasher: messages are sent one byte per
// word, an in-bench sha-256 predicts the eight digest words of every
// message and a monitor compares them in order as they leave the block
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] hash_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_byte_stream_hasher_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_word  (hash_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  // predictor state: a private copy of the hasher's state
  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  int unsigned fill_pos;
  logic [63:0] msg_bits;

  digest_word_t digest_q [$];
  int errors;
  int words_seen;
  int messages_sent;
  int cycle_count;
  bit hold_off;   // long receiver stall
  localparam int CycleLimit = 50000;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, ch, mj;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
         + sha256_pkg::RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
  endtask

  task automatic clear_hasher_state();
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitHash[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    fill_pos = 0;
    msg_bits = '0;
  endtask

  // advance the predictor by one accepted word, queueing any digest it yields
  task automatic predict_digest(logic [7:0] b, logic hb, logic fin);
    digest_word_t d;
    if (hb) begin
      msg_block[fill_pos >> 2] |= 32'(b) << (24 - 8 * (fill_pos & 3));
      fill_pos++;
      if (fill_pos == 64) begin
        compress_msg_block();
        fill_pos = 0;
      end
      msg_bits += 64'd8;
    end
    if (fin) begin
      msg_block[fill_pos >> 2] |= 32'(sha256_pkg::PadByte) << (24 - 8 * (fill_pos & 3));
      if (fill_pos >= 56) compress_msg_block();
      msg_block[14] = msg_bits[63:32];
      msg_block[15] = msg_bits[31:0];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        d.word = hash_state[i];
        d.index = 3'(i);
        d.final_word = (i == 7);
        digest_q.push_back(d);
      end
      clear_hasher_state();
      messages_sent++;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    errors++;
  endtask

  // offer one word after a random gap and wait for it to be taken;
  // valid stays up into the next word when that one has no gap
  task automatic send_word(logic [7:0] b, logic hb, logic fin);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    last      <= fin;
    do @(posedge clk); while (!in_ready);
    predict_digest(b, hb, fin);
  endtask

  task automatic send_message(int len, bit empty_last, bit pattern, logic [7:0] fill);
    for (int i = 0; i < len; i++) begin
      // occasional idle word carrying no byte
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(pattern ? fill : 8'($urandom), 1'b1, (!empty_last) && (i == len - 1));
    end
    if (empty_last || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_message(0, 1, 0, 8'h00);        // empty message
    send_message(3, 1, 1, 8'hff);        // all ones, empty closing word
    send_message(56, 0, 0, 8'h00);       // padding spills to second block
    send_message(64, 0, 0, 8'h00);       // exactly one full block
    wait_drained();
  endtask

  task automatic test_random();
    int len;
    repeat (6) begin
      len = $urandom_range(0, 6);
      send_message(len, 1'($urandom_range(0, 1)), 0, 8'h00);
    end
    wait_drained();
  endtask

  // receiver stalls while the sender keeps offering, so input backs up
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        send_message(8, 0, 0, 8'h00);
        send_message(4, 0, 0, 8'h00);
      end
      begin
        wait (out_valid === 1'b1);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drained();
  endtask

  // receiver: random stalls per word, plus the long hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall != 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !hold_off);
    end
  end

  // monitor: every accepted digest word against the oldest prediction
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected hash_word", hash_word, 32'd0);
      end else begin
        want = digest_q.pop_front();
        if (hash_word !== want.word) report_mismatch("hash_word", hash_word, want.word);
        if (word_index !== want.index)
          report_mismatch("word_index", 32'(word_index), 32'(want.index));
        if (last_word !== want.final_word)
          report_mismatch("last_word", 32'(last_word), 32'(want.final_word));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d digest words outstanding", digest_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0; words_seen = 0; messages_sent = 0; cycle_count = 0; hold_off = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0; data_byte = '0; has_byte = 1'b0; last = 1'b0;
    clear_hasher_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    repeat (200) @(posedge clk);
    $display("%0d messages hashed, %0d digest words checked, incl. padding edges", messages_sent,
             words_seen);
    $display("and a long output stall with the input backed up");
    if (errors == 0 && digest_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
